/* rtl/pidf_pkg.sv */
// Package for the filtered-derivative PID unit: widths, codes, state types
// and the configuration register bundle. No dependencies.
`default_nettype none

package pidf_pkg;

  // Gain fraction width; derivative adds the 16-bit filter fraction.
  localparam int GAIN_FRACTION_BITS = 12;
  localparam int ALPHA_FRAC = 16;

  localparam int SAMPLE_W = 16;
  localparam int ERR_W = SAMPLE_W + 1;
  localparam int PREV_W = ERR_W + 1;
  localparam int INTEG_W = 32;
  localparam int FILT_W = PREV_W + ALPHA_FRAC;
  localparam int GAIN_W = 24;
  localparam int ILIM_W = 31;
  localparam int OLIM_W = 15;
  localparam int BAND_W = 17;
  localparam int ALPHA_W = ALPHA_FRAC + 1;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: unsigned A times signed B, B split in two pieces.
  localparam int MUL_A_W = GAIN_W;
  localparam int MUL_B_W = FILT_W + 1;
  localparam int PIECE_W = 17;
  localparam int HI_W = MUL_B_W - PIECE_W;
  localparam int PP_LO_W = MUL_A_W + PIECE_W;
  localparam int PP_HI_W = MUL_A_W + 1 + HI_W;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  localparam int TOTAL_W = PROD_W - GAIN_FRACTION_BITS + 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } pidf_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_ILIM     = 3'd3,
    REG_OLIM     = 3'd4,
    REG_DEADBAND = 3'd5,
    REG_SEP      = 3'd6,
    REG_ALPHA    = 3'd7
  } pidf_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  proportional_gain;
    logic [GAIN_W-1:0]  integral_gain;
    logic [GAIN_W-1:0]  derivative_gain;
    logic [ILIM_W-1:0]  integral_limit;
    logic [OLIM_W-1:0]  output_limit;
    logic [BAND_W-1:0]  dead_band;
    logic [BAND_W-1:0]  integ_window;
    logic [ALPHA_W-1:0] filter_alpha;
  } pidf_cfg_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_SUM
  } pidf_mul_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_INTEG,
    S_FILT_GO,
    S_FILT_WAIT,
    S_P_GO,
    S_P_WAIT,
    S_I_GO,
    S_I_WAIT,
    S_D_GO,
    S_D_WAIT,
    S_CLAMP,
    S_OUT
  } pidf_state_t;

endpackage

`default_nettype wire

/* rtl/pidf_cfg.sv */
// Configuration register file of the PID unit.
// Depends on pidf_pkg for register codes and the pidf_cfg_t bundle.
`default_nettype none

module pidf_cfg
  import pidf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output pidf_cfg_t                  regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.proportional_gain <= '0;
      regs.integral_gain     <= '0;
      regs.derivative_gain   <= '0;
      regs.integral_limit    <= '0;
      regs.output_limit      <= '1;
      regs.dead_band         <= '0;
      regs.integ_window      <= BAND_W'(1) << 16;
      regs.filter_alpha      <= ALPHA_ONE;
    end else if (cfg_valid) begin
      unique case (pidf_reg_t'(cfg_index))
        REG_KP:       regs.proportional_gain <= cfg_data[GAIN_W-1:0];
        REG_KI:       regs.integral_gain     <= cfg_data[GAIN_W-1:0];
        REG_KD:       regs.derivative_gain   <= cfg_data[GAIN_W-1:0];
        REG_ILIM:     regs.integral_limit    <= cfg_data[ILIM_W-1:0];
        REG_OLIM:     regs.output_limit      <= cfg_data[OLIM_W-1:0];
        REG_DEADBAND: regs.dead_band         <= cfg_data[BAND_W-1:0];
        REG_SEP:      regs.integ_window      <= cfg_data[BAND_W-1:0];
        REG_ALPHA:    regs.filter_alpha      <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/pidf_mul.sv */
// Shared multiplier: unsigned 24-bit A times signed 35-bit B in two passes
// of one 25x18 signed multiplier, then a recombining add. Uses pidf_pkg.
`default_nettype none

module pidf_mul
  import pidf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [MUL_A_W-1:0]        a,
  input  wire logic signed [MUL_B_W-1:0] b,
  output logic                           done,
  output logic signed [PROD_W-1:0]       prod
);

  pidf_mul_state_t state, state_next;

  logic [MUL_A_W-1:0]        a_q;
  logic signed [MUL_B_W-1:0] b_q;
  logic signed [HI_W-1:0]    piece;
  logic signed [PP_HI_W-1:0] mul_out;
  logic [PP_LO_W-1:0]        pp_lo;
  logic signed [PP_HI_W-1:0] pp_hi;
  logic [PROD_W:0]           sum_full;

  always_comb begin
    state_next = state;
    unique case (state)
      MUL_IDLE: if (start) state_next = MUL_LO;
      MUL_LO:   state_next = MUL_HI;
      MUL_HI:   state_next = MUL_SUM;
      MUL_SUM:  state_next = MUL_IDLE;
      default:  state_next = MUL_IDLE;
    endcase
  end

  // Low pass takes B's low bits as unsigned, high pass the signed top.
  always_comb begin
    if (state == MUL_LO) begin
      piece = {{(HI_W - PIECE_W){1'b0}}, b_q[PIECE_W-1:0]};
    end else begin
      piece = b_q[MUL_B_W-1:PIECE_W];
    end
  end

  assign mul_out  = $signed({1'b0, a_q}) * piece;
  assign sum_full = {pp_hi, {PIECE_W{1'b0}}} + {{(PROD_W + 1 - PP_LO_W){1'b0}}, pp_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MUL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MUL_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (state == MUL_IDLE && start) begin
      a_q <= a;
      b_q <= b;
    end
    if (state == MUL_LO) begin
      pp_lo <= mul_out[PP_LO_W-1:0];
    end
    if (state == MUL_HI) begin
      pp_hi <= mul_out;
    end
    if (state == MUL_SUM) begin
      prod <= sum_full[PROD_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/pid_with_filtered_derivative_unit.sv */
// Top level of the PID unit with dead band, integral separation and a
// low-pass filtered derivative. Uses pidf_pkg, pidf_cfg and pidf_mul.
//
//   channel | signals                                | role
//   in      | in_valid, in_ready, opcode, setpoint,  | command or sample pair
//           | measured                               |
//   out     | out_valid, out_ready, drive_value,     | clamped drive and flag
//           | saturated                              |
//   cfg     | cfg_valid, cfg_ready, cfg_index,       | register write
//           | cfg_data                               |
//
// A control step forms the error, updates the integral and the filter, then
// clamps the sum of three products into the output register (the first two
// steps after reset or a clear skip the filter update); a clear loads zero.
// Each product uses the one shared multiplier: a start, two passes, a recombining
// add and a hand-off. Reset is synchronous: loop state clears, registers take
// defaults. in_ready returns as the result loads; a result still waiting holds the next.
`default_nettype none

module pid_with_filtered_derivative_unit
  import pidf_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       opcode,
  input  wire logic signed [SAMPLE_W-1:0] setpoint,
  input  wire logic signed [SAMPLE_W-1:0] measured,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      drive_value,
  output logic                            saturated,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

  pidf_cfg_t   regs;
  pidf_state_t state, state_next;

  logic                      mul_start;
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_prod;

  logic signed [SAMPLE_W-1:0] sp_q;
  logic signed [SAMPLE_W-1:0] ms_q;
  logic signed [ERR_W-1:0]    err_q;
  logic [ERR_W-1:0]           mag_q;
  logic signed [INTEG_W-1:0]  integral;
  logic signed [PREV_W-1:0]   prev_err;
  logic signed [FILT_W-1:0]   filt;
  logic [1:0]                 step_count;
  logic signed [MUL_B_W-1:0]  fil_b;
  logic signed [TOTAL_W-1:0]  total;
  logic signed [SAMPLE_W-1:0] res_drive;
  logic                       res_sat;

  logic signed [ERR_W-1:0]     err_raw;
  logic [ERR_W-1:0]            mag_raw;
  logic signed [INTEG_W:0]     sum_ext;
  logic signed [INTEG_W:0]     lim_ext;
  logic signed [PREV_W-1:0]    diff;
  logic [ALPHA_W-1:0]          alpha_eff;
  logic signed [PROD_W-1:0]    pi_term;
  logic signed [PROD_W-1:0]    d_term;
  logic signed [TOTAL_W-1:0]   olim_ext;
  logic                        out_load;

  pidf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  pidf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Datapath helpers
  assign err_raw   = ERR_W'(sp_q) - ERR_W'(ms_q);
  assign mag_raw   = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : err_raw;
  assign sum_ext   = (INTEG_W + 1)'(integral) + (INTEG_W + 1)'(err_q);
  assign lim_ext   = $signed({2'b00, regs.integral_limit});
  assign diff      = PREV_W'(err_q) - prev_err;
  assign alpha_eff = regs.filter_alpha[ALPHA_FRAC] ? ALPHA_ONE : regs.filter_alpha;
  assign pi_term   = mul_prod >>> GAIN_FRACTION_BITS;
  assign d_term    = mul_prod >>> (GAIN_FRACTION_BITS + ALPHA_FRAC);
  assign olim_ext  = $signed({{(TOTAL_W - OLIM_W){1'b0}}, regs.output_limit});
  assign out_load  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = (opcode == OP_CLEAR) ? S_OUT : S_ERR;
      end
      S_ERR:       state_next = S_INTEG;
      S_INTEG:     state_next = step_count[1] ? S_FILT_GO : S_P_GO;
      S_FILT_GO:   state_next = S_FILT_WAIT;
      S_FILT_WAIT: if (mul_done) state_next = S_P_GO;
      S_P_GO:      state_next = S_P_WAIT;
      S_P_WAIT:    if (mul_done) state_next = S_I_GO;
      S_I_GO:      state_next = S_I_WAIT;
      S_I_WAIT:    if (mul_done) state_next = S_D_GO;
      S_D_GO:      state_next = S_D_WAIT;
      S_D_WAIT:    if (mul_done) state_next = S_CLAMP;
      S_CLAMP:     state_next = S_OUT;
      S_OUT:       if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_FILT_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(alpha_eff);
        mul_b     = fil_b;
      end
      S_P_GO: begin
        mul_start = 1'b1;
        mul_a     = regs.proportional_gain;
        mul_b     = MUL_B_W'(err_q);
      end
      S_I_GO: begin
        mul_start = 1'b1;
        mul_a     = regs.integral_gain;
        mul_b     = MUL_B_W'(integral);
      end
      S_D_GO: begin
        mul_start = 1'b1;
        mul_a     = regs.derivative_gain;
        mul_b     = MUL_B_W'(filt);
      end
      default: ;
    endcase
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      integral   <= '0;
      prev_err   <= '0;
      filt       <= '0;
      step_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && opcode == OP_CLEAR) begin
            integral   <= '0;
            prev_err   <= '0;
            filt       <= '0;
            step_count <= '0;
          end
        end
        S_INTEG: begin
          if (mag_q < regs.integ_window) begin
            priority if (sum_ext > lim_ext) begin
              integral <= INTEG_W'(lim_ext);
            end else if (sum_ext < -lim_ext) begin
              integral <= INTEG_W'(-lim_ext);
            end else begin
              integral <= sum_ext[INTEG_W-1:0];
            end
          end
        end
        S_FILT_WAIT: begin
          if (mul_done) begin
            filt <= filt + mul_prod[FILT_W+ALPHA_FRAC-1:ALPHA_FRAC];
          end
        end
        S_CLAMP: begin
          prev_err <= PREV_W'(err_q);
          if (!step_count[1]) step_count <= step_count + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          sp_q      <= setpoint;
          ms_q      <= measured;
          res_drive <= '0;
          res_sat   <= 1'b0;
        end
      end
      S_ERR: begin
        // drop errors inside the dead band
        if (mag_raw < regs.dead_band) begin
          err_q <= '0;
          mag_q <= '0;
        end else begin
          err_q <= err_raw;
          mag_q <= mag_raw;
        end
      end
      S_INTEG: begin
        fil_b <= {diff[PREV_W-1], diff, {ALPHA_FRAC{1'b0}}} - MUL_B_W'(filt);
      end
      S_P_WAIT: if (mul_done) total <= pi_term[TOTAL_W-1:0];
      S_I_WAIT: if (mul_done) total <= total + pi_term[TOTAL_W-1:0];
      S_D_WAIT: if (mul_done) total <= total + d_term[TOTAL_W-1:0];
      S_CLAMP: begin
        priority if (total > olim_ext) begin
          res_drive <= SAMPLE_W'(olim_ext);
          res_sat   <= 1'b1;
        end else if (total < -olim_ext) begin
          res_drive <= SAMPLE_W'(-olim_ext);
          res_sat   <= 1'b1;
        end else begin
          res_drive <= total[SAMPLE_W-1:0];
          res_sat   <= 1'b0;
        end
      end
      S_OUT: begin
        if (out_load) begin
          drive_value <= res_drive;
          saturated   <= res_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* dv/pidf_scoreboard_pkg.sv */
// Drive-value scoreboard for the filtered-derivative PID unit: keeps its own
// copy of the registers and loop state, predicts each result and checks it.
// Depends on pidf_pkg.
package pidf_scoreboard_pkg;
  import pidf_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] drive_value;
    logic                       saturated;
  } drive_result_t;

  class pidf_drive_scoreboard;
    pidf_cfg_t                 regs;
    logic signed [PREV_W-1:0]  prev_error;
    logic signed [INTEG_W-1:0] error_sum;
    logic signed [FILT_W-1:0]  filt_diff;
    int unsigned               step_count;
    drive_result_t             pending_drives[$];
    int unsigned               mismatches;
    int unsigned               n_steps;
    int unsigned               n_clears;
    int unsigned               n_saturated;
    int unsigned               n_results;

    function new();
      regs = '0;
      regs.output_limit = '1;
      regs.integ_window = 'h10000;
      regs.filter_alpha = ALPHA_ONE;
      mismatches = 0;
      n_steps = 0;
      n_clears = 0;
      n_saturated = 0;
      n_results = 0;
      clear_loop();
    endfunction

    function void clear_loop();
      prev_error = '0;
      error_sum = '0;
      filt_diff = '0;
      step_count = 0;
    endfunction

    function void write_reg(pidf_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KP:       regs.proportional_gain = data[GAIN_W-1:0];
        REG_KI:       regs.integral_gain = data[GAIN_W-1:0];
        REG_KD:       regs.derivative_gain = data[GAIN_W-1:0];
        REG_ILIM:     regs.integral_limit = data[ILIM_W-1:0];
        REG_OLIM:     regs.output_limit = data[OLIM_W-1:0];
        REG_DEADBAND: regs.dead_band = data[BAND_W-1:0];
        REG_SEP:      regs.integ_window = data[BAND_W-1:0];
        REG_ALPHA:    regs.filter_alpha = data[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    // Predict the drive for one accepted command and queue it.
    function void note_command(pidf_op_t op, logic signed [SAMPLE_W-1:0] sp,
                               logic signed [SAMPLE_W-1:0] ms);
      longint err, mag, acc, lim, alpha, one, diff, filt;
      longint p, i, d, total, olim;
      drive_result_t r;
      r.drive_value = '0;
      r.saturated = 1'b0;
      if (op == OP_CLEAR) begin
        clear_loop();
        n_clears++;
        pending_drives.push_back(r);
        return;
      end
      n_steps++;
      err = sp;
      err = err - ms;
      mag = (err < 0) ? -err : err;
      if (mag < longint'(regs.dead_band)) begin
        err = 0;
        mag = 0;
      end

      // Integral separation: hold the sum on large errors.
      if (mag < longint'(regs.integ_window)) begin
        lim = longint'(regs.integral_limit);
        acc = longint'(error_sum) + err;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        error_sum = acc[INTEG_W-1:0];
      end

      filt = longint'(filt_diff);
      if (step_count >= 2) begin
        one = longint'(ALPHA_ONE);
        alpha = longint'(regs.filter_alpha);
        if (alpha > one) alpha = one;
        diff = err - longint'(prev_error);
        filt = ((alpha * diff * one) + (one - alpha) * filt) >>> ALPHA_FRAC;
        filt_diff = filt[FILT_W-1:0];
      end

      p = (longint'(regs.proportional_gain) * err) >>> GAIN_FRACTION_BITS;
      i = (longint'(regs.integral_gain) * longint'(error_sum)) >>> GAIN_FRACTION_BITS;
      d = (longint'(regs.derivative_gain) * filt) >>> (GAIN_FRACTION_BITS + ALPHA_FRAC);
      total = p + i + d;
      olim = longint'(regs.output_limit);
      if (total > olim) begin
        total = olim;
        r.saturated = 1'b1;
      end
      if (total < -olim) begin
        total = -olim;
        r.saturated = 1'b1;
      end
      r.drive_value = total[SAMPLE_W-1:0];
      if (r.saturated) n_saturated++;

      prev_error = err[PREV_W-1:0];
      if (step_count < 2) step_count++;
      pending_drives.push_back(r);
    endfunction

    task check_drive(logic signed [SAMPLE_W-1:0] drive_value, logic saturated);
      drive_result_t want;
      n_results++;
      if (pending_drives.size() == 0) begin
        report($sformatf("result %0d: unexpected transfer drive=%0d saturated=%0b",
                         n_results, drive_value, saturated));
        return;
      end
      want = pending_drives.pop_front();
      if (drive_value !== want.drive_value)
        report($sformatf("result %0d: drive_value %0d, predicted %0d",
                         n_results, drive_value, want.drive_value));
      if (saturated !== want.saturated)
        report($sformatf("result %0d: saturated %0b, predicted %0b",
                         n_results, saturated, want.saturated));
    endtask

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH %s", msg);
    endtask
  endclass

endpackage

/* dv/tb_pid_with_filtered_derivative_unit.sv */
// Testbench top for pid_with_filtered_derivative_unit: directed corner cases,
// then randomized register settings and commands under random stalls.
// Depends on pidf_pkg, pidf_scoreboard_pkg and the RTL.
module tb_pid_with_filtered_derivative_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pidf_pkg::*;
  import pidf_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int TAIL_CYCLES = 30;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  pidf_op_t                   opcode = OP_STEP;
  logic signed [SAMPLE_W-1:0] setpoint = '0;
  logic signed [SAMPLE_W-1:0] measured = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] drive_value;
  logic                       saturated;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  pidf_reg_t                  cfg_index = REG_KP;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  bit                         calm = 1'b0;
  int unsigned                n_settings = 0;
  pidf_drive_scoreboard       sb;

  pid_with_filtered_derivative_unit u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timeout: results still outstanding");
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: check each transfer, then pick the next ready level.
  initial begin : result_side
    int unsigned hold;
    logic        next_ready;
    hold = 0;
    next_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_drive(drive_value, saturated);
      if (calm) begin
        next_ready = 1'b1;
        hold = 0;
      end else if (hold == 0) begin
        if ($urandom_range(99) < 55) begin
          next_ready = 1'b1;
          hold = $urandom_range(1, 8);
        end else begin
          next_ready = 1'b0;
          hold = pick_gap();
        end
      end else begin
        hold--;
      end
      out_ready <= next_ready;
    end
  end

  // Valid stays high across back-to-back transfers; drop it only for a gap.
  task automatic send_item(pidf_op_t op, logic signed [SAMPLE_W-1:0] sp,
                           logic signed [SAMPLE_W-1:0] ms);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    setpoint <= sp;
    measured <= ms;
    do @(posedge clk); while (!in_ready);
    sb.note_command(op, sp, ms);
  endtask

  // Step with a chosen error and a random operating point.
  task automatic send_error(int want);
    int e, lo, hi, ms;
    e = want;
    if (e > 65535) e = 65535;
    if (e < -65535) e = -65535;
    lo = (e > 0) ? -32768 : -32768 - e;
    hi = (e > 0) ? 32767 - e : 32767;
    ms = lo + int'($urandom_range(hi - lo));
    send_item(OP_STEP, SAMPLE_W'(ms + e), SAMPLE_W'(ms));
  endtask

  task automatic send_random_item();
    int unsigned roll;
    int          span, base;
    roll = $urandom_range(99);
    if (roll < 4) begin
      send_item(OP_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    end else if (roll < 30) begin
      send_item(OP_STEP, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    end else if (roll < 80) begin
      case ($urandom_range(2))
        0: span = 20;
        1: span = 400;
        default: span = 5000;
      endcase
      send_error(int'($urandom_range(2 * span)) - span);
    end else begin
      // Land on either side of the dead band or the separation threshold.
      base = $urandom_range(1) ? int'(sb.regs.dead_band) : int'(sb.regs.integ_window);
      base = base + int'($urandom_range(2)) - 1;
      send_error($urandom_range(1) ? base : -base);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(pidf_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic load_setting(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] ki,
                              logic [CFG_DATA_W-1:0] kd, logic [CFG_DATA_W-1:0] ilim,
                              logic [CFG_DATA_W-1:0] olim, logic [CFG_DATA_W-1:0] band,
                              logic [CFG_DATA_W-1:0] sep, logic [CFG_DATA_W-1:0] alpha);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_ILIM, ilim);
    write_reg(REG_OLIM, olim);
    write_reg(REG_DEADBAND, band);
    write_reg(REG_SEP, sep);
    write_reg(REG_ALPHA, alpha);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(pidf_reg_t r);
    logic [CFG_DATA_W-1:0] v, junk;
    int unsigned           roll, w;
    roll = $urandom_range(99);
    case (r)
      REG_KP, REG_KI, REG_KD: begin
        w = GAIN_W;
        if (roll < 10) v = '0;
        else if (roll < 20) v = {GAIN_W{1'b1}};
        else if (roll < 35) v = $urandom_range(2**GAIN_W - 1);
        else v = $urandom_range(16384);
      end
      REG_ILIM: begin
        w = ILIM_W;
        if (roll < 10) v = '0;
        else if (roll < 25) v = '1;
        else if (roll < 50) v = $urandom_range(100);
        else if (roll < 80) v = $urandom_range(200000);
        else v = $urandom;
      end
      REG_OLIM: begin
        w = OLIM_W;
        if (roll < 10) v = '0;
        else if (roll < 25) v = {OLIM_W{1'b1}};
        else if (roll < 45) v = $urandom_range(1000);
        else v = $urandom_range(32767);
      end
      REG_DEADBAND: begin
        w = BAND_W;
        if (roll < 25) v = '0;
        else if (roll < 35) v = 65536;
        else if (roll < 42) v = {BAND_W{1'b1}};
        else if (roll < 50) v = $urandom_range(65536);
        else v = $urandom_range(64);
      end
      REG_SEP: begin
        w = BAND_W;
        if (roll < 30) v = 65536;
        else if (roll < 38) v = '0;
        else if (roll < 45) v = {BAND_W{1'b1}};
        else if (roll < 55) v = $urandom_range(2**BAND_W - 1);
        else v = $urandom_range(100, 4000);
      end
      default: begin
        w = ALPHA_W;
        if (roll < 20) v = ALPHA_ONE;
        else if (roll < 30) v = '0;
        else if (roll < 40) v = $urandom_range(65537, 2**ALPHA_W - 1);
        else v = $urandom_range(65536);
      end
    endcase
    // Now and then set bits above the register width; they must be dropped.
    if ($urandom_range(9) == 0 && w < CFG_DATA_W) begin
      junk = $urandom;
      v = v | (junk << w);
    end
    return v;
  endfunction

  task automatic shuffle_setting(bit every_reg);
    pidf_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      if (every_reg || $urandom_range(1)) write_reg(r, pick_reg_value(r));
      r = r.next();
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    int unsigned sent, burst;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: all gains zero, so the drive stays at zero.
    send_item(OP_STEP, 32767, -32768);
    send_item(OP_STEP, -32768, 32767);
    drain_results();

    // Unity proportional gain: error at and just past the output limit.
    load_setting(4096, 0, 0, 0, 100, 0, 65536, 65536);
    send_error(100);
    send_error(101);
    send_error(-100);
    send_error(-101);
    send_item(OP_STEP, -5, -5);
    drain_results();

    // Full-scale gains and limits, alpha above one, dead band and separation.
    load_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 31'h7FFFFFFF, 32767, 10, 1000,
                 17'h1FFFF);
    send_item(OP_CLEAR, 0, 0);
    send_error(7);
    send_error(500);
    send_error(-2000);
    send_item(OP_STEP, 32767, -32768);
    send_item(OP_STEP, -32768, 32767);
    send_error(3);
    drain_results();

    // Integral limit lowered below the held sum; filter starts on step three.
    load_setting(2048, 4096, 8192, 20, 32767, 0, 65536, 32768);
    send_error(1);
    send_error(30);
    send_error(-100);
    send_error(0);
    send_item(OP_CLEAR, -1, 1);
    send_error(10);
    send_error(20);
    send_error(40);
    drain_results();

    // Zero output limit, dead band swallowing every error, no integration.
    load_setting(4096, 4096, 4096, 0, 0, 65536, 0, 0);
    send_item(OP_STEP, 32767, -32768);
    send_error(-100);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(7) == 0);
      shuffle_setting(n_settings % 3 == 0);
      burst = $urandom_range(20, 70);
      repeat (burst) begin
        send_random_item();
        sent++;
      end
      drain_results();
    end
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d control steps and %0d clears under %0d register settings;",
             sb.n_steps, sb.n_clears, n_settings);
    $display("%0d results were clamped at the output limit.", sb.n_saturated);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* pid_with_filtered_derivative_unit.f */
rtl/pidf_pkg.sv
rtl/pidf_cfg.sv
rtl/pidf_mul.sv
rtl/pid_with_filtered_derivative_unit.sv
dv/pidf_scoreboard_pkg.sv
dv/tb_pid_with_filtered_derivative_unit.sv
